@@ sv/address_threshold_blocker_unit_assert.svh @@
// assertion macros for the address threshold blocker
`ifndef ADDRESS_THRESHOLD_BLOCKER_UNIT_ASSERT_SVH
`define ADDRESS_THRESHOLD_BLOCKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ATB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define ATB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ sv/atb_pkg.sv @@
`default_nettype none
package atb_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // commands
    localparam logic CMD_LOG   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // event classes
    localparam logic [2:0] EV_OTHER     = 3'd0;
    localparam logic [2:0] EV_AUTH_FAIL = 3'd1;
    localparam logic [2:0] EV_ATTACK    = 3'd2;
    localparam logic [2:0] EV_INJECTION = 3'd3;
    localparam logic [2:0] EV_TRAVERSAL = 3'd4;
    localparam logic [2:0] EV_DOS       = 3'd5;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTH_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOS_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALERTS_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEV_MIN      = 3'd5;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  event_type;
        logic [2:0]  severity;
        logic [31:0] source_address;
        logic [31:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic        allowed;
        logic        newly_blocked;
        logic        alert_raised;
        logic        table_full;
        logic [31:0] logged_count;
        logic [31:0] alerted_count;
        logic [31:0] addresses_blocked;
    } result_t;

    typedef struct packed {
        logic [31:0] window_seconds;
        logic [31:0] auth_fail_limit;
        logic [31:0] attack_limit;
        logic [31:0] dos_limit;
        logic        alerts_enabled;
        logic [2:0]  alert_severity_min;
    } cfg_t;

    // per-entry record kept in the record ram
    typedef struct packed {
        logic [31:0] auth_fail_count;
        logic [31:0] attack_count;
        logic [31:0] dos_count;
        logic [31:0] origin_time;
        logic        blocked_mark;
    } rec_t;

    typedef struct packed {
        logic allowed;
        logic newly_blocked;
        logic alert_raised;
    } upd_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

@@ sv/atb_ram.sv @@
`default_nettype none
module atb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sv/atb_cfg_regs.sv @@
`default_nettype none
module atb_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [atb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_wdata,
    output atb_pkg::cfg_t                          cfg
);

    atb_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_seconds     <= 32'd300;
            cfg_reg.auth_fail_limit    <= 32'd5;
            cfg_reg.attack_limit       <= 32'd3;
            cfg_reg.dos_limit          <= 32'd10;
            cfg_reg.alerts_enabled     <= 1'b0;
            cfg_reg.alert_severity_min <= 3'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                atb_pkg::REG_WINDOW:       cfg_reg.window_seconds     <= cfg_wdata;
                atb_pkg::REG_AUTH_LIMIT:   cfg_reg.auth_fail_limit    <= cfg_wdata;
                atb_pkg::REG_ATTACK_LIMIT: cfg_reg.attack_limit       <= cfg_wdata;
                atb_pkg::REG_DOS_LIMIT:    cfg_reg.dos_limit          <= cfg_wdata;
                atb_pkg::REG_ALERTS_EN:    cfg_reg.alerts_enabled     <= cfg_wdata[0];
                atb_pkg::REG_SEV_MIN:      cfg_reg.alert_severity_min <= cfg_wdata[2:0];
                default:                   ; // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ sv/atb_update.sv @@
`default_nettype none
module atb_update (
    input  wire atb_pkg::in_item_t item,
    input  wire atb_pkg::cfg_t     cfg,
    input  wire atb_pkg::rec_t     rec_cur,
    input  wire logic              rec_valid,
    output atb_pkg::rec_t          rec_new,
    output atb_pkg::upd_flags_t    flags
);

    logic        is_log;
    logic        is_attack;
    logic [32:0] win_end;
    logic        in_window;
    logic        limit_hit;
    logic        newly;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    always_comb
    begin
        is_log    = (item.cmd == atb_pkg::CMD_LOG);
        is_attack = (item.event_type == atb_pkg::EV_ATTACK) ||
                    (item.event_type == atb_pkg::EV_INJECTION) ||
                    (item.event_type == atb_pkg::EV_TRAVERSAL);

        rec_new = rec_cur;
        if (is_log)
        begin
            if (item.event_type == atb_pkg::EV_AUTH_FAIL)
            begin
                rec_new.auth_fail_count = sat_inc(rec_cur.auth_fail_count);
            end
            if (is_attack)
            begin
                rec_new.attack_count = sat_inc(rec_cur.attack_count);
            end
            if (item.event_type == atb_pkg::EV_DOS)
            begin
                rec_new.dos_count = sat_inc(rec_cur.dos_count);
            end
        end

        // origin > now - window, kept exact as origin + window > now
        win_end   = {1'b0, rec_cur.origin_time} + {1'b0, cfg.window_seconds};
        in_window = win_end > {1'b0, item.now_seconds};
        limit_hit = (rec_new.auth_fail_count >= cfg.auth_fail_limit) ||
                    (rec_new.attack_count >= cfg.attack_limit) ||
                    (rec_new.dos_count >= cfg.dos_limit);

        newly = is_log && rec_valid && !rec_cur.blocked_mark && in_window && limit_hit;
        rec_new.blocked_mark = rec_cur.blocked_mark | newly;

        flags.newly_blocked = newly;
        flags.allowed       = !(rec_valid && rec_new.blocked_mark);
        flags.alert_raised  = is_log && cfg.alerts_enabled &&
                              (item.severity >= cfg.alert_severity_min);
    end

endmodule
`default_nettype wire

@@ sv/address_threshold_blocker_unit.sv @@
// channel    | direction | handshake                 | payload
// -----------+-----------+---------------------------+------------------------
// item       | in        | start high, busy low      | atb_pkg::in_item_t
// result     | out       | done strobe, one cycle    | atb_pkg::result_t
// config     | in        | cfg_we, no wait           | cfg_index, cfg_wdata
//
// the time from accept to the done strobe is set by the scan of the address ram,
// one entry compared per cycle, which ends at a match or at the fill count
// reset clears the fill count and totals; table rams are not cleared, only
// entries below the fill count are ever read
// the receiver cannot stall: each result shows on done for exactly one cycle
`default_nettype none
module address_threshold_blocker_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire atb_pkg::in_item_t             item,
    output logic                               done,
    output atb_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [atb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_wdata
);

`include "address_threshold_blocker_unit_assert.svh"

    localparam int IDX_W = atb_pkg::IDX_W;
    localparam int CNT_W = atb_pkg::CNT_W;
    localparam int REC_W = $bits(atb_pkg::rec_t);

    // control state
    atb_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;       // fill count of the table
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;   // next entry to read in the scan
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next; // entry whose address is on the ram output
    logic              pend_reg, pend_next;       // ram output holds a valid compare
    logic              hit_reg, hit_next;
    logic [31:0]       logged_reg, logged_next;
    logic [31:0]       alert_tot_reg, alert_tot_next;
    logic [31:0]       blocked_tot_reg, blocked_tot_next;
    logic              done_reg, done_next;

    // payload
    atb_pkg::in_item_t item_reg, item_next;
    atb_pkg::result_t  result_reg, result_next;

    // config and ram wiring
    atb_pkg::cfg_t       cfg;
    logic                addr_we;
    logic [IDX_W-1:0]    addr_waddr;
    logic [31:0]         addr_rdata;
    logic                rec_we;
    logic [IDX_W-1:0]    rec_waddr;
    logic [REC_W-1:0]    rec_rdata;
    atb_pkg::rec_t       rec_cur;
    atb_pkg::rec_t       rec_new;
    atb_pkg::rec_t       rec_fresh;
    logic                rec_valid;
    atb_pkg::upd_flags_t flags;
    logic                match;
    logic                room;
    logic                insert;

    atb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // address ram: scanned one entry per cycle
    atb_ram #(
        .WIDTH (32),
        .DEPTH (atb_pkg::TABLE_DEPTH)
    ) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (addr_waddr),
        .wdata (item_reg.source_address),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (addr_rdata)
    );

    // record ram: counters, first-seen time and blocked mark per entry;
    // read during the scan, written back only in the finish cycle, so the
    // sequencer itself keeps reads and writes of one entry apart
    atb_ram #(
        .WIDTH (REC_W),
        .DEPTH (atb_pkg::TABLE_DEPTH)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_new),
        .raddr (cmp_idx_reg),
        .rdata (rec_rdata)
    );

    // read-modify-write of the selected record
    atb_update u_update (
        .item      (item_reg),
        .cfg       (cfg),
        .rec_cur   (rec_cur),
        .rec_valid (rec_valid),
        .rec_new   (rec_new),
        .flags     (flags)
    );

    // new entry: zero counters, first seen now, not blocked
    always_comb
    begin
        rec_fresh             = '0;
        rec_fresh.origin_time = item_reg.now_seconds;
    end

    assign match     = pend_reg && (addr_rdata == item_reg.source_address);
    assign room      = used_reg < atb_pkg::DEPTH_CNT;
    assign insert    = !hit_reg && room;
    assign rec_valid = hit_reg || insert;
    assign rec_cur   = hit_reg ? atb_pkg::rec_t'(rec_rdata) : rec_fresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= atb_pkg::ST_IDLE;
            used_reg        <= '0;
            rd_idx_reg      <= '0;
            cmp_idx_reg     <= '0;
            pend_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            logged_reg      <= '0;
            alert_tot_reg   <= '0;
            blocked_tot_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            rd_idx_reg      <= rd_idx_next;
            cmp_idx_reg     <= cmp_idx_next;
            pend_reg        <= pend_next;
            hit_reg         <= hit_next;
            logged_reg      <= logged_next;
            alert_tot_reg   <= alert_tot_next;
            blocked_tot_reg <= blocked_tot_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    // sequencer: accept, scan, finish
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        pend_next        = pend_reg;
        hit_next         = hit_reg;
        logged_next      = logged_reg;
        alert_tot_next   = alert_tot_reg;
        blocked_tot_next = blocked_tot_reg;
        done_next        = 1'b0;
        item_next        = item_reg;
        result_next      = result_reg;
        addr_we          = 1'b0;
        addr_waddr       = used_reg[IDX_W-1:0];
        rec_we           = 1'b0;
        rec_waddr        = hit_reg ? cmp_idx_reg : used_reg[IDX_W-1:0];

        unique case (state_reg)
            atb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = atb_pkg::ST_SEARCH;
                end
            end

            atb_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    // hold cmp_idx so the record ram reads the hit entry
                    hit_next   = 1'b1;
                    state_next = atb_pkg::ST_FINISH;
                end
                else if (rd_idx_reg < used_reg)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = atb_pkg::ST_FINISH;
                end
            end

            atb_pkg::ST_FINISH:
            begin
                addr_we = insert;
                rec_we  = insert || (hit_reg && (item_reg.cmd == atb_pkg::CMD_LOG));
                if (insert)
                begin
                    used_next = used_reg + CNT_W'(1);
                end
                if (item_reg.cmd == atb_pkg::CMD_LOG)
                begin
                    logged_next = logged_reg + 32'd1;
                end
                if (flags.alert_raised)
                begin
                    alert_tot_next = alert_tot_reg + 32'd1;
                end
                if (flags.newly_blocked)
                begin
                    blocked_tot_next = blocked_tot_reg + 32'd1;
                end
                result_next.allowed           = flags.allowed;
                result_next.newly_blocked     = flags.newly_blocked;
                result_next.alert_raised      = flags.alert_raised;
                result_next.table_full        = !hit_reg && !room;
                result_next.logged_count      = logged_next;
                result_next.alerted_count     = alert_tot_next;
                result_next.addresses_blocked = blocked_tot_next;
                done_next  = 1'b1;
                pend_next  = 1'b0;
                state_next = atb_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = atb_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != atb_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // checks on the sequencer
    `ATB_ASSERT_SAME(a_done_after_finish, done_reg, $past(state_reg == atb_pkg::ST_FINISH))
    `ATB_ASSERT_SAME(a_used_bound, 1'b1, used_reg <= atb_pkg::DEPTH_CNT)
    `ATB_ASSERT_NEXT(a_start_to_search, start && !busy, state_reg == atb_pkg::ST_SEARCH)
    `ATB_ASSERT_SAME(a_newly_not_allowed, done_reg && result_reg.newly_blocked, !result_reg.allowed)

endmodule
`default_nettype wire

@@ tb/sv/address_threshold_blocker_unit_tb.sv @@
module address_threshold_blocker_unit_tb;
    import atb_pkg::*;

    // clock, reset and run length
    localparam int     CLK_HALF      = 2;
    localparam int     RESET_CYCLES  = 11;
    localparam int     PHASE_ITEMS   = 93;
    localparam int     POOL_SIZE     = 40;
    // one scan of a full table plus the fixed overhead, with margin
    localparam int     DRAIN_CYCLES  = TABLE_DEPTH + 16;
    // worst case is every transfer scanning the full table, taken several times over
    localparam longint TIMEOUT_TICKS = 64'd24_000_000;

    // event codes outside the defined classes, treated like other
    localparam logic [2:0] EV_SPARE_6 = 3'd6;
    localparam logic [2:0] EV_SPARE_7 = 3'd7;

    // register indexes past the end of the map, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // addresses used by the directed rows
    localparam logic [31:0] ADDR_FLOOR = 32'h0000_0000;
    localparam logic [31:0] ADDR_CEIL  = 32'hFFFF_FFFF;
    localparam logic [31:0] ADDR_AUTH  = 32'h8000_0001;
    localparam logic [31:0] ADDR_DOS   = 32'h7FFF_FFFE;
    localparam logic [31:0] ADDR_STALE = 32'h0A00_0001;

    // one directed transfer, with its result typed in where it is obvious
    typedef struct packed {
        logic        cmd;
        logic [2:0]  ev;
        logic [2:0]  sev;
        logic [31:0] addr;
        logic [31:0] now;
        logic        typed;
        result_t     want;
    } probe_row_t;

    localparam int N_PROBES = 22;

    // default settings in force: window 300, limits 5/3/10, alerts off
    localparam probe_row_t PROBE_ROWS [N_PROBES] = '{
        // first check after reset inserts the all-zero address
        '{CMD_CHECK, EV_OTHER,     3'd0, ADDR_FLOOR, 32'd0, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
        // all-ones address and time, no class, alerts still off
        '{CMD_LOG,   EV_OTHER,     3'd7, ADDR_CEIL, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd1, 32'd0, 32'd0}},
        // unknown classes leave the counters alone
        '{CMD_LOG,   EV_SPARE_6,   3'd0, ADDR_FLOOR, 32'd1, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd2, 32'd0, 32'd0}},
        '{CMD_LOG,   EV_SPARE_7,   3'd3, ADDR_FLOOR, 32'd2, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd3, 32'd0, 32'd0}},
        // attack, injection and traversal share one counter, third one blocks
        '{CMD_LOG,   EV_ATTACK,    3'd1, ADDR_FLOOR, 32'd10, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd4, 32'd0, 32'd0}},
        '{CMD_LOG,   EV_INJECTION, 3'd2, ADDR_FLOOR, 32'd11, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd5, 32'd0, 32'd0}},
        '{CMD_LOG,   EV_TRAVERSAL, 3'd4, ADDR_FLOOR, 32'd12, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 32'd6, 32'd0, 32'd1}},
        // already blocked stays blocked without a new block
        '{CMD_LOG,   EV_ATTACK,    3'd5, ADDR_FLOOR, 32'd13, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 32'd7, 32'd0, 32'd1}},
        // check does not touch counters or totals
        '{CMD_CHECK, EV_DOS,       3'd7, ADDR_FLOOR, 32'd14, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 32'd7, 32'd0, 32'd1}},
        // five auth failures inside the window
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd6, ADDR_AUTH, 32'd100, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd8, 32'd0, 32'd1}},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd6, ADDR_AUTH, 32'd101, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd9, 32'd0, 32'd1}},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd6, ADDR_AUTH, 32'd102, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd10, 32'd0, 32'd1}},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd6, ADDR_AUTH, 32'd103, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 32'd11, 32'd0, 32'd1}},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd6, ADDR_AUTH, 32'd104, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 32'd12, 32'd0, 32'd2}},
        // denial of service class
        '{CMD_LOG,   EV_DOS,       3'd7, ADDR_DOS, 32'd5000, 1'b0, '0},
        // limit reached only after the window has passed, no block
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd0, ADDR_STALE, 32'd1000, 1'b0, '0},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd1, ADDR_STALE, 32'd1001, 1'b0, '0},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd2, ADDR_STALE, 32'd1002, 1'b0, '0},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd3, ADDR_STALE, 32'd1003, 1'b0, '0},
        '{CMD_LOG,   EV_AUTH_FAIL, 3'd4, ADDR_STALE, 32'd1400, 1'b0, '0},
        '{CMD_CHECK, EV_OTHER,     3'd5, ADDR_STALE, 32'd1400, 1'b0, '0},
        // blocked address seen by a check
        '{CMD_CHECK, EV_OTHER,     3'd0, ADDR_AUTH, 32'd1500, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 32'd18, 32'd0, 32'd2}}
    };

    // one queued register write
    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
    } reg_write_t;

    // dut ports
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_item_t             item;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_wdata;

    // shadow of the block: settings, address table and running totals
    cfg_t        live_cfg;
    logic [31:0] tab_addr    [TABLE_DEPTH];
    logic [31:0] tab_auth    [TABLE_DEPTH];
    logic [31:0] tab_attack  [TABLE_DEPTH];
    logic [31:0] tab_dos     [TABLE_DEPTH];
    logic [31:0] tab_first   [TABLE_DEPTH];
    logic        tab_blocked [TABLE_DEPTH];
    int          fill_count;
    logic [31:0] logged_sum;
    logic [31:0] alert_sum;
    logic [31:0] blocked_sum;

    // verdicts still owed by the block, oldest first
    result_t     verdict_q [$];
    reg_write_t  write_q [$];

    // stimulus state
    logic [31:0] watch_addrs [POOL_SIZE];
    logic [31:0] wall_now;

    // bookkeeping
    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int blocks_seen     = 0;
    int alerts_seen     = 0;
    int full_seen       = 0;

    address_threshold_blocker_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // free-running clock, period 4
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_TICKS);
        $display("%0t: timeout, %0d verdicts still owed", $time, verdict_q.size());
        $display("address_threshold_blocker_unit_tb: errors");
        $finish;
    end

    // linear search of the used part of the shadow table, -1 on a miss
    function automatic int find_slot(input logic [31:0] addr);
        int i;
        for (i = 0; i < fill_count; i++)
        begin
            if (tab_addr[i] == addr)
                return i;
        end
        return -1;
    endfunction

    // counters stick at all ones
    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // verdict for one accepted transfer, advancing the shadow state
    function automatic result_t predict_verdict(input in_item_t it);
        result_t r;
        int      slot;
        logic    in_window;
        logic    over_limit;
        r         = '0;
        r.allowed = 1'b1;
        slot      = find_slot(it.source_address);
        // a miss takes the next free entry, if there is one
        if (slot < 0 && fill_count < TABLE_DEPTH)
        begin
            slot              = fill_count;
            tab_addr[slot]    = it.source_address;
            tab_auth[slot]    = '0;
            tab_attack[slot]  = '0;
            tab_dos[slot]     = '0;
            tab_first[slot]   = it.now_seconds;
            tab_blocked[slot] = 1'b0;
            fill_count++;
        end
        r.table_full = (slot < 0);
        if (it.cmd == CMD_LOG)
        begin
            if (slot >= 0)
            begin
                case (it.event_type)
                    EV_AUTH_FAIL:
                        tab_auth[slot] = sat_bump(tab_auth[slot]);
                    EV_ATTACK, EV_INJECTION, EV_TRAVERSAL:
                        tab_attack[slot] = sat_bump(tab_attack[slot]);
                    EV_DOS:
                        tab_dos[slot] = sat_bump(tab_dos[slot]);
                    default:
                        ;
                endcase
                // first sighting > now - window, done without wraparound
                in_window  = ({1'b0, tab_first[slot]} + {1'b0, live_cfg.window_seconds})
                             > {1'b0, it.now_seconds};
                over_limit = (tab_auth[slot] >= live_cfg.auth_fail_limit)
                          || (tab_attack[slot] >= live_cfg.attack_limit)
                          || (tab_dos[slot] >= live_cfg.dos_limit);
                if (!tab_blocked[slot] && in_window && over_limit)
                begin
                    tab_blocked[slot] = 1'b1;
                    blocked_sum       = blocked_sum + 32'd1;
                    r.newly_blocked   = 1'b1;
                end
            end
            logged_sum = logged_sum + 32'd1;
            if (live_cfg.alerts_enabled && it.severity >= live_cfg.alert_severity_min)
            begin
                alert_sum      = alert_sum + 32'd1;
                r.alert_raised = 1'b1;
            end
        end
        if (slot >= 0 && tab_blocked[slot])
            r.allowed = 1'b0;
        r.logged_count      = logged_sum;
        r.alerted_count     = alert_sum;
        r.addresses_blocked = blocked_sum;
        return r;
    endfunction

    // mirror of a register write; indexes past the map do nothing
    function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [31:0] data);
        case (idx)
            REG_WINDOW:       live_cfg.window_seconds     = data;
            REG_AUTH_LIMIT:   live_cfg.auth_fail_limit    = data;
            REG_ATTACK_LIMIT: live_cfg.attack_limit       = data;
            REG_DOS_LIMIT:    live_cfg.dos_limit          = data;
            REG_ALERTS_EN:    live_cfg.alerts_enabled     = data[0];
            REG_SEV_MIN:      live_cfg.alert_severity_min = data[2:0];
            default:          ;
        endcase
    endfunction

    // time source: mostly small steps, now and then a jump anywhere
    function automatic logic [31:0] next_now();
        if ($urandom_range(0, 99) < 3)
            wall_now = $urandom();
        else
            wall_now = wall_now + 32'($urandom_range(0, 40));
        return wall_now;
    endfunction

    // mostly the watched addresses, sometimes a fresh one
    function automatic logic [31:0] pick_address();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return watch_addrs[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic void field_check(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare one result transfer against the oldest owed verdict
    task automatic check_result(input result_t got);
        result_t want;
        if (verdict_q.size() == 0)
        begin
            $display("%0t: result with nothing owed, got %h", $time, got);
            errors++;
            return;
        end
        want = verdict_q.pop_front();
        results_checked++;
        field_check("allowed",       32'(want.allowed),       32'(got.allowed));
        field_check("newly_blocked", 32'(want.newly_blocked), 32'(got.newly_blocked));
        field_check("alert_raised",  32'(want.alert_raised),  32'(got.alert_raised));
        field_check("table_full",    32'(want.table_full),    32'(got.table_full));
        field_check("logged_count",      want.logged_count,      got.logged_count);
        field_check("alerted_count",     want.alerted_count,     got.alerted_count);
        field_check("addresses_blocked", want.addresses_blocked, got.addresses_blocked);
        if (got.newly_blocked === 1'b1)
            blocks_seen++;
        if (got.alert_raised === 1'b1)
            alerts_seen++;
        if (got.table_full === 1'b1)
            full_seen++;
    endtask

    // result side: one transfer per cycle with done high, no back-pressure
    always @(posedge clk)
    begin
        if (rst_n && done)
            check_result(result);
    end

    // sender idles each cycle with the given chance in a hundred
    task automatic idle_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // one item transfer; start stays high until the block takes it
    task automatic send_item(input in_item_t it, input int idle_pct,
                             input logic typed, input result_t typed_want);
        result_t want;
        idle_gap(idle_pct);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // taken at this edge
        want = predict_verdict(it);
        verdict_q.push_back(typed ? typed_want : want);
        items_sent++;
    endtask

    // drop start and wait until every owed verdict is in and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // queued register writes go out back to back
    task automatic program_regs();
        reg_write_t w;
        while (write_q.size() != 0)
        begin
            w = write_q.pop_front();
            cfg_we    <= 1'b1;
            cfg_index <= w.idx;
            cfg_wdata <= w.data;
            @(posedge clk);
            note_reg_write(w.idx, w.data);
        end
        cfg_we <= 1'b0;
    endtask

    // new setting between phases; junk in the unused upper bits of the narrow ones
    task automatic apply_setting(input cfg_t s);
        logic [31:0] junk;
        int          i;
        settle();
        // keep the two extreme addresses, refresh the rest so blocks keep happening
        for (i = 2; i < POOL_SIZE; i++)
            watch_addrs[i] = $urandom();
        junk = $urandom();
        write_q.push_back('{REG_WINDOW,       s.window_seconds});
        write_q.push_back('{REG_AUTH_LIMIT,   s.auth_fail_limit});
        write_q.push_back('{REG_ATTACK_LIMIT, s.attack_limit});
        write_q.push_back('{REG_DOS_LIMIT,    s.dos_limit});
        write_q.push_back('{REG_ALERTS_EN,    {junk[31:1], s.alerts_enabled}});
        write_q.push_back('{REG_SEV_MIN,      {junk[31:3], s.alert_severity_min}});
        program_regs();
    endtask

    // random phase: runs of events from one address, plus noise
    task automatic run_phase(input int n_items, input int idle_pct);
        in_item_t   it;
        int         stop_at;
        int         burst;
        logic [2:0] ev_class;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            // now and then the sender holds off until the block has caught up
            if ($urandom_range(0, 49) == 0)
                settle();
            if ($urandom_range(0, 99) < 70)
            begin
                // a run of one class from one address, the way blocks get reached
                it.source_address = pick_address();
                ev_class          = 3'($urandom_range(1, 5));
                burst             = $urandom_range(1, 6);
                repeat (burst)
                begin
                    it.cmd        = ($urandom_range(0, 9) == 0) ? CMD_CHECK : CMD_LOG;
                    it.event_type = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                               : ev_class;
                    it.severity    = 3'($urandom_range(0, 7));
                    it.now_seconds = next_now();
                    send_item(it, idle_pct, 1'b0, '0);
                end
            end
            else
            begin
                it.cmd            = ($urandom_range(0, 1) == 0) ? CMD_LOG : CMD_CHECK;
                it.event_type     = 3'($urandom_range(0, 7));
                it.severity       = 3'($urandom_range(0, 7));
                it.source_address = pick_address();
                it.now_seconds    = next_now();
                send_item(it, idle_pct, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        in_item_t it;
        cfg_t     s;
        int       i;
        int       directed_count;
        int       random_count;

        // everything known from time zero, reset held
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;

        // shadow starts at the reset values
        live_cfg    = '{window_seconds: 32'd300, auth_fail_limit: 32'd5, attack_limit: 32'd3,
                        dos_limit: 32'd10, alerts_enabled: 1'b0, alert_severity_min: 3'd2};
        fill_count  = 0;
        logged_sum  = '0;
        alert_sum   = '0;
        blocked_sum = '0;
        wall_now    = 32'd2000;
        watch_addrs[0] = ADDR_FLOOR;
        watch_addrs[1] = ADDR_CEIL;
        for (i = 2; i < POOL_SIZE; i++)
            watch_addrs[i] = $urandom();

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset settings, back to back
        for (i = 0; i < N_PROBES; i++)
        begin
            it.cmd            = PROBE_ROWS[i].cmd;
            it.event_type     = PROBE_ROWS[i].ev;
            it.severity       = PROBE_ROWS[i].sev;
            it.source_address = PROBE_ROWS[i].addr;
            it.now_seconds    = PROBE_ROWS[i].now;
            send_item(it, 0, PROBE_ROWS[i].typed, PROBE_ROWS[i].want);
        end
        directed_count = items_sent;

        // ordinary thresholds, alerts on, no idling
        s = '{window_seconds: 32'd300, auth_fail_limit: 32'd3, attack_limit: 32'd2,
              dos_limit: 32'd4, alerts_enabled: 1'b1, alert_severity_min: 3'd2};
        apply_setting(s);
        run_phase(PHASE_ITEMS, 0);

        // small random thresholds and window, sender idle about half the time
        s = '{window_seconds: 32'($urandom_range(10, 400)),
              auth_fail_limit: 32'($urandom_range(1, 6)),
              attack_limit: 32'($urandom_range(1, 6)),
              dos_limit: 32'($urandom_range(1, 6)),
              alerts_enabled: 1'b1, alert_severity_min: 3'($urandom_range(0, 7))};
        apply_setting(s);
        run_phase(PHASE_ITEMS, 51);

        // limits at their top never trip, alerts off; unmapped indexes written too
        s = '{window_seconds: $urandom(), auth_fail_limit: '1, attack_limit: '1,
              dos_limit: '1, alerts_enabled: 1'b0, alert_severity_min: 3'd0};
        apply_setting(s);
        write_q.push_back('{REG_SPARE_6, $urandom()});
        write_q.push_back('{REG_SPARE_7, $urandom()});
        program_regs();
        run_phase(PHASE_ITEMS, 0);

        // random again with the sender idle about a quarter of the time
        s = '{window_seconds: 32'($urandom_range(10, 400)),
              auth_fail_limit: 32'($urandom_range(1, 6)),
              attack_limit: 32'($urandom_range(1, 6)),
              dos_limit: 32'($urandom_range(1, 6)),
              alerts_enabled: 1'b1, alert_severity_min: 3'($urandom_range(0, 7))};
        apply_setting(s);
        run_phase(PHASE_ITEMS, 28);

        // zero window: only a first sighting later than now can block
        s = '{window_seconds: '0, auth_fail_limit: '0, attack_limit: '0, dos_limit: '0,
              alerts_enabled: 1'b1, alert_severity_min: 3'd0};
        apply_setting(s);
        run_phase(PHASE_ITEMS, 51);

        // widest window with zero limits: every log in the table blocks
        s = '{window_seconds: '1, auth_fail_limit: '0, attack_limit: '0, dos_limit: '0,
              alerts_enabled: 1'b1, alert_severity_min: 3'd7};
        apply_setting(s);
        run_phase(PHASE_ITEMS, 28);
        random_count = items_sent - directed_count;

        // let everything drain, then a full scan's worth of quiet
        settle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
            errors = errors + verdict_q.size();
        end

        $display("covered %0d transfers: %0d directed, %0d random over six settings",
                 items_sent, directed_count, random_count);
        $display("checked %0d results with %0d new blocks, %0d alerts, %0d table-full flags",
                 results_checked, blocks_seen, alerts_seen, full_seen);
        if (errors == 0)
            $display("address_threshold_blocker_unit_tb: clean");
        else
            $display("address_threshold_blocker_unit_tb: errors");
        $finish;
    end

endmodule

@@ address_threshold_blocker_unit.f @@
+incdir+sv
sv/atb_pkg.sv
sv/atb_ram.sv
sv/atb_cfg_regs.sv
sv/atb_update.sv
sv/address_threshold_blocker_unit.sv
tb/sv/address_threshold_blocker_unit_tb.sv
